FILE: design/itmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmp_pkg: shared types and constants of the i2c target memory pointer
// Holds the transfer structs, the sequencer and phase codes and the
// command codes of the target command engine.
// ----------------------------------------------------------------------------
package itmp_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned MEM_DEPTH_DEF = 4096;
  // bank * 128 + register fits in this many bits
  localparam int unsigned SUM_W         = 16;

  localparam logic [2:0] CMD_POINTER = 3'd0;
  localparam logic [2:0] CMD_MEMORY  = 3'd1;
  localparam logic [2:0] CMD_ERROR   = 3'd7;

  localparam logic [BYTE_W-1:0] ERR_REPLY = 8'hFD;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              is_data;
    logic              master_nack;
  } in_t;

  typedef struct packed {
    logic              load_tx;
    logic [BYTE_W-1:0] tx_byte;
    logic              release_clock;
  } out_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_WRITE = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    SQ_CLEAR,
    SQ_RUN,
    SQ_RD_LO,
    SQ_RD_HI
  } seq_e;

endpackage

FILE: design/itmp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmp_ram: single-port byte memory
// One access per cycle, read data registered and held until the next read.
// ----------------------------------------------------------------------------
module itmp_ram #(
  parameter int unsigned Depth = itmp_pkg::MEM_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          we_i,
  input  logic [$clog2(Depth)-1:0]      addr_i,
  input  logic [itmp_pkg::BYTE_W-1:0]   wdata_i,
  output logic [itmp_pkg::BYTE_W-1:0]   rdata_o
);
  import itmp_pkg::*;

  logic [BYTE_W-1:0] mem_q [Depth];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/i2c_target_memory_pointer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_target_memory_pointer: byte-level i2c target command engine
// Decodes address and data byte events into pointer, memory and error
// commands and produces one transmit/clock-release result per event.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------
//  in      | input     | in_valid_i / in_stall_o | in_data_i  (in_t)
//  out     | output    | out_valid_o/ out_stall_i| out_data_o (out_t)
//
//  a new transfer can be taken every cycle, except during a memory read
//  a memory read command (read, command 1) does two reads on the
//  single memory port, then the result is loaded
//  a completed pointer write folds bank*128+register into the address range
//  in the same cycle by keeping the low bits (MEM_DEPTH must be a power of
//  two; the block does not check it); after reset a clearing pass zeroes
//  the memory, during which no transfer is taken; results sit in an output
//  register; otherwise input is taken when it is empty or drains that cycle
// ----------------------------------------------------------------------------
module i2c_target_memory_pointer #(
  parameter int unsigned MEM_DEPTH = itmp_pkg::MEM_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  itmp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output itmp_pkg::out_t out_data_o
);
  import itmp_pkg::*;

  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam logic [AW-1:0] ADDR_LAST = AW'(MEM_DEPTH - 1);

  // architectural state
  phase_e            phase_q, phase_d;
  logic [2:0]        cmd_q, cmd_d;
  logic [1:0]        left_q, left_d;
  logic              err_q, err_d;
  logic [BYTE_W-1:0] bank_q, bank_d;
  logic [BYTE_W-1:0] reg_q, reg_d;
  logic [BYTE_W-1:0] held_q, held_d;

  // sequencer and address bookkeeping
  seq_e              seq_q, seq_d;
  logic [AW-1:0]     clr_q;
  logic [AW-1:0]     base_q;
  logic [AW-1:0]     base_nxt;
  logic [SUM_W-1:0]  ptr_sum;
  logic [BYTE_W-1:0] tx_q;

  // output register
  logic              out_valid_q;
  out_t              out_q;
  out_t              res;
  out_t              out_d;
  logic              out_load;
  logic              out_free;

  // item decode
  logic              accept;
  logic [2:0]        cmd_in;
  logic [1:0]        left_dec;
  logic              idle_ph;
  logic              mem_rd_go;
  logic              mem_wr_go;
  logic              ptr_go;

  // memory port
  logic              ram_en;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;

  itmp_ram #(
    .Depth (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;
  assign cmd_in   = in_data_i.rx_byte[3:1];
  assign left_dec = left_q - 2'd1;
  // unused phase code is handled as idle
  assign idle_ph  = (phase_q != PH_READ) && (phase_q != PH_WRITE);

  assign mem_rd_go = accept && idle_ph && !in_data_i.is_data && in_data_i.rx_byte[0]
                     && (cmd_in == CMD_MEMORY);
  assign mem_wr_go = accept && (phase_q == PH_WRITE) && (left_dec == 2'd0)
                     && (cmd_q == CMD_MEMORY);
  assign ptr_go    = accept && (phase_q == PH_WRITE) && (left_dec == 2'd0)
                     && (cmd_q == CMD_POINTER);

  // second memory byte sits one entry up, wrapping at the top
  assign base_nxt = (base_q == ADDR_LAST) ? '0 : base_q + AW'(1);

  // new pointer as a flat byte address, low bits give it modulo the depth
  assign ptr_sum = SUM_W'({bank_d, 7'b0}) + SUM_W'(reg_d);

  // per-event command decode
  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    left_d  = left_q;
    err_d   = err_q;
    bank_d  = bank_q;
    reg_d   = reg_q;
    held_d  = held_q;
    res     = '0;
    case (phase_q)
      PH_READ: begin
        if (!in_data_i.master_nack) begin
          res.load_tx       = 1'b1;
          res.tx_byte       = held_q;
          res.release_clock = 1'b1;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_WRITE: begin
        left_d = left_dec;
        if (left_dec == 2'd0) begin
          case (cmd_q)
            CMD_POINTER: begin
              bank_d = held_q;
              reg_d  = in_data_i.rx_byte;
            end
            CMD_MEMORY: begin
              // store goes through the memory port
            end
            default: begin
              err_d = 1'b1;
            end
          endcase
          phase_d = PH_IDLE;
        end else begin
          held_d = in_data_i.rx_byte;
        end
        res.release_clock = 1'b1;
      end
      default: begin
        if (!in_data_i.is_data) begin
          cmd_d = cmd_in;
          if (!in_data_i.rx_byte[0]) begin
            phase_d = PH_WRITE;
            left_d  = 2'd2;
          end else begin
            phase_d     = PH_READ;
            res.load_tx = 1'b1;
            case (cmd_in)
              CMD_POINTER: begin
                res.tx_byte = bank_q;
                held_d      = reg_q;
              end
              CMD_MEMORY: begin
                // reply comes from two memory reads
              end
              CMD_ERROR: begin
                res.tx_byte = {{(BYTE_W-1){1'b0}}, err_q};
                err_d       = 1'b0;
              end
              default: begin
                res.tx_byte = ERR_REPLY;
                err_d       = 1'b1;
              end
            endcase
          end
          res.release_clock = 1'b1;
        end
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SQ_CLEAR: begin
        if (clr_q == ADDR_LAST) begin
          seq_d = SQ_RUN;
        end
      end
      SQ_RUN: begin
        if (mem_rd_go) begin
          seq_d = SQ_RD_LO;
        end
      end
      SQ_RD_LO: begin
        seq_d = SQ_RD_HI;
      end
      SQ_RD_HI: begin
        if (out_free) begin
          seq_d = SQ_RUN;
        end
      end
      default: begin
        seq_d = SQ_RUN;
      end
    endcase
  end

  // sequencer outputs: memory port, input stall, result load
  always_comb begin
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = base_q;
    ram_wdata  = held_q;
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    out_d      = res;
    case (seq_q)
      SQ_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      SQ_RUN: begin
        in_stall_o = !out_free;
        ram_en     = mem_rd_go || mem_wr_go;
        ram_we     = mem_wr_go;
        out_load   = accept && !mem_rd_go;
      end
      SQ_RD_LO: begin
        ram_en   = 1'b1;
        ram_addr = base_nxt;
      end
      SQ_RD_HI: begin
        out_load      = out_free;
        out_d.load_tx = 1'b1;
        out_d.tx_byte = tx_q;
        out_d.release_clock = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SQ_CLEAR;
      clr_q       <= '0;
      phase_q     <= PH_IDLE;
      cmd_q       <= '0;
      left_q      <= '0;
      err_q       <= 1'b0;
      bank_q      <= '0;
      reg_q       <= '0;
      held_q      <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q <= seq_d;
      if (seq_q == SQ_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (accept) begin
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        left_q  <= left_d;
        err_q   <= err_d;
        bank_q  <= bank_d;
        reg_q   <= reg_d;
        held_q  <= held_d;
      end else if (seq_q == SQ_RD_HI && out_free) begin
        held_q <= ram_rdata;
      end
      if (ptr_go) begin
        base_q <= ptr_sum[AW-1:0];
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
    if (seq_q == SQ_RD_LO) begin
      tx_q <= ram_rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // no memory write may slip in between the two reads of a memory reply
  a_no_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_RD_LO || seq_q == SQ_RD_HI) |-> !ram_we)
    else $error("memory written during memory read sequence");

  // a memory read command always goes to the second read next cycle
  a_read_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_rd_go |=> (seq_q == SQ_RD_LO))
    else $error("memory read command did not start read sequence");

  // reduced base address stays inside the memory
  a_base_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_RUN) |-> (base_q <= ADDR_LAST))
    else $error("base address out of range");

  // byte countdown is only live in the write phase
  a_left_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_WRITE) |-> (left_q == 2'd0))
    else $error("byte countdown nonzero outside write phase");

  // a transmitted byte always comes with the clock released
  a_load_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.release_clock || !out_data_o.load_tx))
    else $error("byte loaded with clock held");
`endif

endmodule
